/* hdl/track_read_cache_core_assert.svh */
// Assertion macros for the track read cache core.
// Included by files that check their own logic; no other dependencies.
`ifndef TRACK_READ_CACHE_CORE_ASSERT_SVH
`define TRACK_READ_CACHE_CORE_ASSERT_SVH

// Same-cycle implication, skipped while reset is asserted.
`define TRC_ASSERT_IMP(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (lhs) |-> (rhs)) \
        else $error(msg);

// Next-cycle implication, skipped while reset is asserted.
`define TRC_ASSERT_NXT(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (lhs) |=> (rhs)) \
        else $error(msg);

`endif

/* hdl/trc_pkg.sv */
// Shared types and constants for the track read cache core.
// No dependencies; imported by every module of the block.
package trc_pkg;

    // Sizing
    localparam int MAX_TRACK_SECTORS = 32;
    localparam int SECTOR_WIDTH      = 32;
    localparam int SECTOR_SHIFT      = 9;     // 512 bytes per sector
    localparam int ADDR_W            = 32;
    localparam int COUNT_W           = 8;
    localparam int SPT_W             = 6;
    localparam int OFF_W             = 5;
    localparam int KIND_W            = 3;
    localparam int CNT_W             = $clog2(SECTOR_WIDTH);
    localparam int CFG_IDX_W         = 2;

    // Result kinds
    localparam logic [KIND_W-1:0] K_COPY   = 3'd0;
    localparam logic [KIND_W-1:0] K_FILL   = 3'd1;
    localparam logic [KIND_W-1:0] K_DIRECT = 3'd2;
    localparam logic [KIND_W-1:0] K_DONE   = 3'd3;
    localparam logic [KIND_W-1:0] K_ERROR  = 3'd4;

    // Input operations
    localparam logic OP_REQUEST    = 1'b0;
    localparam logic OP_COMPLETION = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CACHE_ENABLE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SECTORS_PER_TRACK = 2'd1;

    typedef struct packed {
        logic                    operation;
        logic [SECTOR_WIDTH-1:0] start_sector;
        logic [COUNT_W-1:0]      sector_count;
        logic [ADDR_W-1:0]       dest_addr;
        logic                    fill_ok;
    } t_in_item;

    typedef struct packed {
        logic [KIND_W-1:0]       kind;
        logic [SECTOR_WIDTH-1:0] disk_sector;
        logic [OFF_W-1:0]        cache_offset;
        logic [ADDR_W-1:0]       copy_dest;
        logic [COUNT_W-1:0]      run_length;
        logic                    last;
    } t_out_item;

    // Remainder unit status
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

endpackage

/* hdl/trc_rem_unit.sv */
// Bit-serial remainder unit: sector number modulo sectors per track.
// Depends on trc_pkg; one dividend bit is consumed per cycle.
module trc_rem_unit import trc_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [SECTOR_WIDTH-1:0] i_dividend,
    input  logic [SPT_W-1:0]        i_divisor,
    output t_div_status             o_status,
    output logic [SPT_W-1:0]        o_rem
);

    logic                    r_busy;
    logic                    r_done;
    logic [CNT_W-1:0]        r_cnt;
    logic [SECTOR_WIDTH-1:0] r_shift;
    logic [SPT_W-1:0]        r_rem;

    logic [SPT_W:0]          n_trial;
    logic [SPT_W-1:0]        n_rem;

    // Shift in the next dividend bit and subtract when it fits
    always_comb begin
        n_trial = {r_rem, r_shift[SECTOR_WIDTH-1]};
        if (n_trial >= {1'b0, i_divisor}) begin
            n_rem = SPT_W'(n_trial - {1'b0, i_divisor});
        end else begin
            n_rem = n_trial[SPT_W-1:0];
        end
    end

    // Step the sequence, one bit a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_shift <= i_dividend;
            r_rem   <= '0;
            r_cnt   <= CNT_W'(SECTOR_WIDTH - 1);
        end else if (r_busy) begin
            r_shift <= {r_shift[SECTOR_WIDTH-2:0], 1'b0};
            r_rem   <= n_rem;
            r_cnt   <= r_cnt - 1'b1;
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_rem         = r_rem;

endmodule

/* hdl/track_read_cache_core.sv */
// Top level of the track read cache core: request sequencer and result register.
// Depends on trc_pkg, trc_rem_unit and track_read_cache_core_assert.svh.

// Serves sector read requests from a one-track cache and issues copy, fill,
// direct-read, done and error results, up to two per input item. One item is
// worked at a time and the input stalls until its last result is loaded into
// the output register. An item that ends in a track fill waits on the
// bit-serial remainder unit, which rounds the sector down to its track base
// at one bit per cycle. A stalled output holds the sequencer until the result
// is taken. The configuration port is always ready and a write to either
// configuration register unprimes the cache.
module track_read_cache_core import trc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_item,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [SPT_W-1:0]     i_cfg_data
);

`include "track_read_cache_core_assert.svh"

    // Sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SERVE = 3'd1;
    localparam logic [2:0] S_DIVGO = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_FILL  = 3'd4;
    localparam logic [2:0] S_PUT   = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    // Pending operation codes
    localparam logic [1:0] W_IDLE   = 2'd0;
    localparam logic [1:0] W_FILL   = 2'd1;
    localparam logic [1:0] W_DIRECT = 2'd2;

    logic [2:0]              r_state;
    logic [2:0]              r_after;
    logic                    r_enable;
    logic [SPT_W-1:0]        r_spt;
    logic                    r_primed;
    logic [SECTOR_WIDTH-1:0] r_ts;
    logic [SECTOR_WIDTH-1:0] r_ns;
    logic [COUNT_W-1:0]      r_left;
    logic [ADDR_W-1:0]       r_dest;
    logic [1:0]              r_waiting;
    t_out_item               r_res;
    logic                    r_out_valid;
    t_out_item               r_out_item;

    logic                    in_xfer;
    logic                    out_free;
    logic                    usable;
    logic [SECTOR_WIDTH:0]   n_diff;
    logic                    n_hit;
    logic [OFF_W-1:0]        n_off;
    logic [SPT_W-1:0]        n_avail;
    logic [COUNT_W-1:0]      n_k;
    logic [COUNT_W-1:0]      n_left;
    logic                    div_start;
    t_div_status             div_stat;
    logic [SPT_W-1:0]        div_rem;

    // Build a result from its fields
    function automatic t_out_item make_res(input logic [KIND_W-1:0]       kind,
                                           input logic [SECTOR_WIDTH-1:0] disk,
                                           input logic [OFF_W-1:0]        off,
                                           input logic [ADDR_W-1:0]       dest,
                                           input logic [COUNT_W-1:0]      run,
                                           input logic                    last);
        t_out_item res;
        res              = '0;
        res.kind         = kind;
        res.disk_sector  = disk;
        res.cache_offset = off;
        res.copy_dest    = dest;
        res.run_length   = run;
        res.last         = last;
        return res;
    endfunction

    assign in_xfer     = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign usable      = r_enable && (r_spt != '0) &&
                         ({1'b0, r_spt} <= (SPT_W+1)'(MAX_TRACK_SECTORS));

    // Hit test and copy run for the current position
    always_comb begin
        n_diff  = {1'b0, r_ns} - {1'b0, r_ts};
        n_hit   = r_primed && !n_diff[SECTOR_WIDTH] &&
                  (n_diff[SECTOR_WIDTH-1:0] < SECTOR_WIDTH'(r_spt));
        n_off   = n_diff[OFF_W-1:0];
        n_avail = r_spt - {1'b0, n_off};
        n_k     = (r_left < COUNT_W'(n_avail)) ? r_left : COUNT_W'(n_avail);
        n_left  = r_left - n_k;
    end

    assign div_start = (r_state == S_DIVGO);

    trc_rem_unit u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_ns),
        .i_divisor  (r_spt),
        .o_status   (div_stat),
        .o_rem      (div_rem)
    );

    // Sequencer and cache state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_after   <= S_IDLE;
            r_enable  <= 1'b0;
            r_spt     <= SPT_W'(18);
            r_primed  <= 1'b0;
            r_ts      <= '1;
            r_ns      <= '0;
            r_left    <= '0;
            r_dest    <= '0;
            r_waiting <= W_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_after <= S_IDLE;
                        if (i_in_item.operation == OP_REQUEST) begin
                            if (r_waiting != W_IDLE) begin
                                r_res   <= make_res(K_ERROR, '0, '0, '0, '0, 1'b1);
                                r_state <= S_PUT;
                            end else if (i_in_item.sector_count == '0) begin
                                r_res   <= make_res(K_DONE, '0, '0, '0, '0, 1'b1);
                                r_state <= S_PUT;
                            end else if (!usable) begin
                                r_res     <= make_res(K_DIRECT, i_in_item.start_sector, '0,
                                                      i_in_item.dest_addr,
                                                      i_in_item.sector_count, 1'b1);
                                r_waiting <= W_DIRECT;
                                r_state   <= S_PUT;
                            end else begin
                                r_ns    <= i_in_item.start_sector;
                                r_left  <= i_in_item.sector_count;
                                r_dest  <= i_in_item.dest_addr;
                                r_state <= S_SERVE;
                            end
                        end else begin
                            if (r_waiting == W_DIRECT) begin
                                r_res     <= make_res(i_in_item.fill_ok ? K_DONE : K_ERROR,
                                                      '0, '0, '0, '0, 1'b1);
                                r_waiting <= W_IDLE;
                                r_state   <= S_PUT;
                            end else if (r_waiting == W_FILL) begin
                                if (i_in_item.fill_ok) begin
                                    r_primed <= 1'b1;
                                    r_state  <= S_SERVE;
                                end else begin
                                    r_primed  <= 1'b0;
                                    r_enable  <= 1'b0;
                                    r_left    <= '0;
                                    r_waiting <= W_IDLE;
                                    r_res     <= make_res(K_ERROR, '0, '0, '0, '0, 1'b1);
                                    r_state   <= S_PUT;
                                end
                            end
                        end
                    end
                end
                S_SERVE: begin
                    if (n_hit) begin
                        r_res   <= make_res(K_COPY, '0, n_off, r_dest, n_k, 1'b0);
                        r_ns    <= r_ns + SECTOR_WIDTH'(n_k);
                        r_dest  <= r_dest + (ADDR_W'(n_k) << SECTOR_SHIFT);
                        r_left  <= n_left;
                        r_after <= (n_left == '0) ? S_DONE : S_DIVGO;
                        r_state <= S_PUT;
                    end else begin
                        r_state <= S_DIVGO;
                    end
                end
                S_DIVGO: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (div_stat.done) begin
                        r_state <= S_FILL;
                    end
                end
                S_FILL: begin
                    // Track base is the sector minus its remainder
                    r_res     <= make_res(K_FILL, r_ns - SECTOR_WIDTH'(div_rem), '0, '0,
                                          COUNT_W'(r_spt), 1'b1);
                    r_ts      <= r_ns - SECTOR_WIDTH'(div_rem);
                    r_primed  <= 1'b0;
                    r_waiting <= W_FILL;
                    r_after   <= S_IDLE;
                    r_state   <= S_PUT;
                end
                S_PUT: begin
                    if (out_free) begin
                        r_state <= r_after;
                    end
                end
                S_DONE: begin
                    r_res     <= make_res(K_DONE, '0, '0, '0, '0, 1'b1);
                    r_waiting <= W_IDLE;
                    r_after   <= S_IDLE;
                    r_state   <= S_PUT;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // Apply configuration writes; a write to either register unprimes the cache
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_CACHE_ENABLE: begin
                        r_enable  <= i_cfg_data[0];
                        r_primed  <= 1'b0;
                        r_waiting <= W_IDLE;
                        r_left    <= '0;
                    end
                    CFG_SECTORS_PER_TRACK: begin
                        r_spt     <= i_cfg_data;
                        r_primed  <= 1'b0;
                        r_waiting <= W_IDLE;
                        r_left    <= '0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Hold the result until the transfer completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_PUT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_PUT && out_free) begin
            r_out_item <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Checks on the sequencer and results
    `TRC_ASSERT_IMP(a_fill_shape, i_clk, i_rst_n,
        o_out_valid && o_out_item.kind == K_FILL,
        o_out_item.last && o_out_item.run_length == COUNT_W'(r_spt),
        "fill result must be last and cover one whole track")
    `TRC_ASSERT_IMP(a_copy_not_last, i_clk, i_rst_n,
        o_out_valid && o_out_item.kind == K_COPY,
        !o_out_item.last && o_out_item.run_length != '0,
        "copy result must be nonempty and followed by another result")
    `TRC_ASSERT_IMP(a_fill_unprimed, i_clk, i_rst_n,
        r_state == S_IDLE && r_waiting == W_FILL,
        !r_primed,
        "cache primed while a fill is outstanding")
    `TRC_ASSERT_NXT(a_div_done, i_clk, i_rst_n,
        div_stat.done,
        r_state == S_FILL,
        "remainder unit finished outside the fill sequence")

endmodule
